// File: hdl/prt_pkg.sv
// Shared types and constants of the page remap table.
package prt_pkg;

   localparam int unsigned ADDRESS_BITS   = 22;
   localparam int unsigned PAGE_BITS      = 12;
   localparam int unsigned ENTRY_BITS     = 5;
   localparam int unsigned DIRECTORY_BITS = 5;
   localparam int unsigned TARGET_BITS    = 40;

   localparam int unsigned FRAME_BITS  = TARGET_BITS - PAGE_BITS;
   localparam int unsigned SLOT_BITS   = DIRECTORY_BITS + ENTRY_BITS;
   localparam int unsigned STORE_DEPTH = 1 << SLOT_BITS;

   localparam logic [1:0] KIND_MAP    = 2'd0;
   localparam logic [1:0] KIND_UNMAP  = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   typedef struct packed {
      logic                  present;
      logic                  ro_flag;
      logic [FRAME_BITS-1:0] frame;
   } entry_type;

endpackage

// File: hdl/page_remap_table.sv
// Page remap table: map, unmap and lookup of page translations in a flat store.
//
// Usage:
//   req channel: one request per transfer; tuser carries the request kind
//   (map, unmap, lookup), tdata the page address, target address and the
//   read-only flag. rsp channel: exactly one result per request, in order.
//   csr channel: writes memory_limit; requests at or above it are out of range
//   and leave the table untouched. Write it only while no request is in flight.
// Timing:
//   A request is accepted every cycle when the result side keeps up, outside
//   the sweep. The store is a RAM with one write and one registered read port;
//   a request reads it on acceptance and writes back as it leaves stage 1, with
//   the last write forwarded to the following read; the result is then registered.
// Reset:
//   memory_limit clears to 0. A clearing sweep then zeros all 1024 entries,
//   one per cycle; req_tready stays low until the sweep is done.
// Backpressure:
//   When rsp_tready is low a valid result is held, a full stage 1 holds, and
//   req_tready drops while stage 1 is full until the result register can move again.
module page_remap_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // address[21:0], target_address[61:22], ro_flag[62], 0
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // ok[0], entry_present[1], entry_ro_flag[2],
                                   // entry_frame[30:3], 0
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [21:0] csr_data
);

   localparam int unsigned SB = prt_pkg::SLOT_BITS;
   localparam int unsigned FB = prt_pkg::FRAME_BITS;
   localparam int unsigned PB = prt_pkg::PAGE_BITS;
   localparam int unsigned AB = prt_pkg::ADDRESS_BITS;

   // request fields
   logic [1:0]    req_kind;
   logic [21:0]   req_address;
   logic [39:0]   req_target;
   logic          req_ro_flag;
   logic [SB-1:0] req_slot;
   logic          req_accept;

   assign req_kind      = req_tuser;
   assign req_address   = req_tdata[21:0];
   assign req_target    = req_tdata[61:22];
   assign req_ro_flag   = req_tdata[62];
   assign req_slot      = req_address[PB +: SB];

   // config
   logic [21:0] limit_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data & 22'((64'd1 << AB) - 64'd1);
      end
   end

   // clearing sweep after reset
   logic [SB:0] clr_cnt_ff, clr_cnt_in;
   logic        clearing;

   assign clearing   = !clr_cnt_ff[SB];
   assign clr_cnt_in = clr_cnt_ff + (SB+1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (clearing) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // stage 1: request waiting on RAM read data
   logic                s1_valid_ff;
   logic [1:0]          s1_kind_ff;
   logic [SB-1:0]       s1_slot_ff;
   logic                s1_inside_ff;
   logic                s1_ro_flag_ff;
   logic [FB-1:0]       s1_frame_ff;
   prt_pkg::entry_type  rd_data_ff;

   // last write, forwarded to a read issued on the same edge
   logic                wr_valid_ff;
   logic [SB-1:0]       wr_slot_ff;
   prt_pkg::entry_type  wr_data_ff;

   // result register
   logic                rsp_valid_ff;
   logic [31:0]         rsp_data_ff;

   logic advance;
   logic s1_done;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign s1_done    = s1_valid_ff && advance;
   assign req_tready = !clearing && (!s1_valid_ff || advance);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff      <= req_kind;
         s1_slot_ff      <= req_slot;
         s1_inside_ff    <= req_address < limit_ff;
         s1_ro_flag_ff   <= req_ro_flag;
         s1_frame_ff     <= req_target[PB +: FB];
      end
   end

   // read-modify-write of the entry
   prt_pkg::entry_type cur_entry;
   prt_pkg::entry_type new_entry;
   logic               do_write;
   logic               res_ok;
   prt_pkg::entry_type res_entry;

   assign cur_entry = (wr_valid_ff && wr_slot_ff == s1_slot_ff) ? wr_data_ff : rd_data_ff;

   always_comb begin
      new_entry = cur_entry;
      do_write  = 1'b0;
      res_ok    = 1'b0;
      res_entry = '0;
      if (s1_inside_ff) begin
         unique case (s1_kind_ff)
            prt_pkg::KIND_MAP: begin
               res_ok              = cur_entry.present;
               do_write            = 1'b1;
               new_entry.present   = 1'b1;
               new_entry.ro_flag   = s1_ro_flag_ff;
               new_entry.frame     = s1_frame_ff;
            end
            prt_pkg::KIND_UNMAP: begin
               do_write          = 1'b1;
               new_entry.present = 1'b0;
            end
            prt_pkg::KIND_LOOKUP: begin
               res_ok    = cur_entry.present;
               res_entry = cur_entry;
            end
            default: begin
               do_write = 1'b0;
            end
         endcase
      end
   end

   // RAM port: sweep writes first, then request write-back
   prt_pkg::entry_type entry_mem_ff [prt_pkg::STORE_DEPTH];
   logic               mem_we;
   logic [SB-1:0]      mem_addr;
   prt_pkg::entry_type mem_wdata;

   always_comb begin
      if (clearing) begin
         mem_we    = 1'b1;
         mem_addr  = clr_cnt_ff[SB-1:0];
         mem_wdata = '0;
      end else begin
         mem_we    = s1_done && do_write;
         mem_addr  = s1_slot_ff;
         mem_wdata = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= entry_mem_ff[req_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (s1_done) begin
         wr_valid_ff <= do_write;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_done) begin
         wr_slot_ff <= s1_slot_ff;
         wr_data_ff <= new_entry;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_done) begin
         rsp_data_ff <= {1'b0, res_entry.frame, res_entry.ro_flag, res_entry.present, res_ok};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("request accepted during clearing sweep");

   a_sweep_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline busy during clearing sweep");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while stage 1 is stalled");

   a_present_implies_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("present entry reported without hit");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request lost before stage 1");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the page remap table: map, unmap and lookup streams.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned ADDR_W   = prt_pkg::ADDRESS_BITS;
   localparam int unsigned PAGE_W   = prt_pkg::PAGE_BITS;
   localparam int unsigned SLOT_W   = prt_pkg::SLOT_BITS;
   localparam int unsigned FRAME_W  = prt_pkg::FRAME_BITS;
   localparam int unsigned TARGET_W = prt_pkg::TARGET_BITS;
   localparam int unsigned DEPTH    = prt_pkg::STORE_DEPTH;

   // Request kind that the block must treat as a no-op with an all-zero result.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int HOT_COUNT   = 16;       // pages that random traffic keeps hitting
   localparam int PHASE_ITEMS = 365;      // random requests per idling phase
   localparam int CYCLE_LIMIT = 200000;   // sweep + ~1500 requests, many times over

   // Expected response: hit/previous-present flag plus the entry as read.
   typedef struct packed {
      logic               ok;
      prt_pkg::entry_type entry;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // address[21:0], target_address[61:22], ro_flag[62], 0
   logic [1:0]  req_tuser = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;        // ok[0], entry_present[1], entry_ro_flag[2],
                                  // entry_frame[30:3], 0
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [21:0] csr_data = '0;

   // Shadow copy of the table and of memory_limit.
   logic               shadow_present [DEPTH];
   logic               shadow_ro_flag [DEPTH];
   logic [FRAME_W-1:0] shadow_frame   [DEPTH];
   logic [ADDR_W-1:0]  memory_limit_cfg = '0;

   result_type expected_results[$];
   logic [SLOT_W-1:0] hot_pages[HOT_COUNT];

   int sender_idle_pct = 0;
   int sink_stall_pct  = 0;
   int cycle_count     = 0;
   int error_count     = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int lookup_hits     = 0;
   int limit_writes    = 0;

   page_remap_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: the run must drain well before this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Result side backpressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // Translation predictor: returns the result for one request and updates the
   // shadow table. Out-of-range requests and the unused kind leave it untouched.
   function automatic result_type predict_translation(
      input logic [1:0]          kind,
      input logic [ADDR_W-1:0]   addr,
      input logic [TARGET_W-1:0] target,
      input logic                ro_flag
   );
      result_type res;
      logic [SLOT_W-1:0] slot;
      res  = '0;
      slot = addr[PAGE_W +: SLOT_W];
      if (addr < memory_limit_cfg) begin
         case (kind)
            prt_pkg::KIND_MAP: begin
               res.ok               = shadow_present[slot];
               shadow_present[slot] = 1'b1;
               shadow_ro_flag[slot] = ro_flag;
               shadow_frame[slot]   = target[TARGET_W-1:PAGE_W];
            end
            prt_pkg::KIND_UNMAP: begin
               // only present drops; frame and flag stay readable
               shadow_present[slot] = 1'b0;
            end
            prt_pkg::KIND_LOOKUP: begin
               res.ok              = shadow_present[slot];
               res.entry.present   = shadow_present[slot];
               res.entry.ro_flag   = shadow_ro_flag[slot];
               res.entry.frame     = shadow_frame[slot];
               if (shadow_present[slot]) lookup_hits++;
            end
            default: begin
            end
         endcase
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name,
                  exp_val, act_val);
         error_count++;
      end
   endtask

   // Result checker: every transfer on rsp is matched against the oldest prediction.
   always @(posedge clock) begin
      result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            check_field("ok", exp_res.ok, rsp_tdata[0]);
            check_field("entry_present", exp_res.entry.present, rsp_tdata[1]);
            check_field("entry_ro_flag", exp_res.entry.ro_flag, rsp_tdata[2]);
            check_field("entry_frame", exp_res.entry.frame, rsp_tdata[30:3]);
            results_checked++;
         end
      end
   end

   // One request transfer, with a random idle gap ahead of it. Valid is only
   // lowered when a gap is taken, so back-to-back transfers keep it high.
   task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                               input logic [TARGET_W-1:0] target, input logic ro_flag);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, ro_flag, target, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_translation(kind, addr, target, ro_flag));
      items_sent++;
   endtask

   // Stop sending and wait until every predicted result has been seen.
   task automatic drain_table();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write memory_limit while idle, then pick hot pages inside the new range.
   task automatic write_memory_limit(input logic [ADDR_W-1:0] limit);
      logic [SLOT_W-1:0] top_page;
      drain_table();
      csr_valid <= 1'b1;
      csr_data  <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      memory_limit_cfg = limit;
      limit_writes++;
      top_page = (limit == 0) ? '1 : SLOT_W'((limit - 1) >> PAGE_W);
      hot_pages[0] = '0;
      hot_pages[1] = top_page;
      for (int i = 2; i < HOT_COUNT; i++) hot_pages[i] = SLOT_W'($urandom_range(top_page));
   endtask

   // Mostly in-range traffic on a few hot pages so maps, unmaps and lookups
   // collide; the rest sits around the limit or is fully random.
   task automatic send_random_request();
      logic [1:0]          kind;
      logic [ADDR_W-1:0]   addr;
      logic [TARGET_W-1:0] target;
      int                  pick;
      pick = $urandom_range(99);
      if (pick < 35) kind = prt_pkg::KIND_MAP;
      else if (pick < 50) kind = prt_pkg::KIND_UNMAP;
      else if (pick < 96) kind = prt_pkg::KIND_LOOKUP;
      else kind = KIND_UNUSED;
      pick = $urandom_range(99);
      if (pick < 65)
         addr = {hot_pages[$urandom_range(HOT_COUNT-1)], PAGE_W'($urandom)};
      else if (pick < 80)
         addr = memory_limit_cfg + ADDR_W'($urandom_range(4)) - ADDR_W'(2);
      else
         addr = ADDR_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 10) target = '1;
      else if (pick < 15) target = '0;
      else target = TARGET_W'({$urandom, $urandom});
      send_request(kind, addr, target, 1'($urandom));
   endtask

   task automatic run_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [ADDR_W-1:0] limit,
                                     input bit pause_midway);
      write_memory_limit(limit);
      sender_idle_pct = idle_pct;
      sink_stall_pct  = stall_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         // sender holds off until the pipe is empty, then resumes
         if (pause_midway && n == PHASE_ITEMS / 2) drain_table();
         send_random_request();
      end
   endtask

   // Reset limit is zero: everything is out of range.
   task automatic test_out_of_range_at_reset();
      send_request(prt_pkg::KIND_MAP, 22'h000000, 40'hFF_FFFF_FFFF, 1'b1);
      send_request(prt_pkg::KIND_LOOKUP, 22'h000000, '0, 1'b0);
      send_request(prt_pkg::KIND_UNMAP, 22'h000000, '0, 1'b0);
      send_request(prt_pkg::KIND_LOOKUP, 22'h3FFFFF, '0, 1'b0);
   endtask

   // Full range: never-written reads, remap, unmap keeping the old entry,
   // out-of-range at the top address, unused kind.
   task automatic test_map_unmap_lookup();
      write_memory_limit(22'h3FFFFF);
      send_request(prt_pkg::KIND_LOOKUP, 22'h000000, '0, 1'b0);
      send_request(prt_pkg::KIND_MAP, 22'h000000, 40'hFF_FFFF_FFFF, 1'b1);
      send_request(prt_pkg::KIND_LOOKUP, 22'h000FFF, '0, 1'b0);
      send_request(prt_pkg::KIND_MAP, 22'h000000, 40'h00_0000_0000, 1'b0);
      send_request(prt_pkg::KIND_LOOKUP, 22'h000000, '0, 1'b0);
      send_request(prt_pkg::KIND_MAP, 22'h3FF000, 40'hA5_5A3C_C3FF, 1'b1);
      send_request(prt_pkg::KIND_LOOKUP, 22'h3FFFFE, '0, 1'b0);
      send_request(prt_pkg::KIND_LOOKUP, 22'h3FFFFF, '0, 1'b0);
      send_request(prt_pkg::KIND_MAP, 22'h3FFFFF, 40'h12_3456_7000, 1'b0);
      send_request(prt_pkg::KIND_LOOKUP, 22'h3FF000, '0, 1'b0);
      send_request(prt_pkg::KIND_UNMAP, 22'h3FF000, '0, 1'b0);
      send_request(prt_pkg::KIND_LOOKUP, 22'h3FF000, '0, 1'b0);
      send_request(prt_pkg::KIND_UNMAP, 22'h3FFFFF, '0, 1'b0);
      send_request(KIND_UNUSED, 22'h000000, 40'hFF_FFFF_FFFF, 1'b1);
      send_request(prt_pkg::KIND_LOOKUP, 22'h000000, '0, 1'b0);
      send_request(prt_pkg::KIND_MAP, 22'h3FF000, 40'h5A_A5C3_3C00, 1'b0);
   endtask

   // Edges of the range: limit 1 allows address 0 only; a page-aligned limit.
   task automatic test_limit_boundaries();
      write_memory_limit(22'h000001);
      send_request(prt_pkg::KIND_MAP, 22'h000000, 40'h00_0000_1000, 1'b1);
      send_request(prt_pkg::KIND_LOOKUP, 22'h000001, '0, 1'b0);
      send_request(prt_pkg::KIND_LOOKUP, 22'h000000, '0, 1'b0);
      write_memory_limit(22'h001000);
      send_request(prt_pkg::KIND_LOOKUP, 22'h000FFF, '0, 1'b0);
      send_request(prt_pkg::KIND_LOOKUP, 22'h001000, '0, 1'b0);
   endtask

   task automatic test_streaming_full_rate();
      run_random_traffic(0, 0, 22'h3FFFFF, 1'b0);
   endtask

   task automatic test_sender_gaps();
      run_random_traffic(73, 0, ADDR_W'($urandom), 1'b0);
   endtask

   task automatic test_receiver_stalls();
      // few pages in range, so hot pages collide constantly
      run_random_traffic(0, 73, 22'h003000, 1'b0);
   endtask

   task automatic test_mixed_idling();
      run_random_traffic(15, 15, 22'h2ABCDE, 1'b1);
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         shadow_present[i] = 1'b0;
         shadow_ro_flag[i] = 1'b0;
         shadow_frame[i]   = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_out_of_range_at_reset();
      test_map_unmap_lookup();
      test_limit_boundaries();
      test_streaming_full_rate();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();

      drain_table();
      repeat (16) @(posedge clock);
      $display("Run covered %0d requests under %0d memory_limit settings and four idling modes;",
               items_sent, limit_writes);
      $display("%0d results checked, %0d lookup hits, %0d errors.", results_checked,
               lookup_hits, error_count);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/prt_pkg.sv
hdl/page_remap_table.sv
sim/tb_top.sv
